[rtl/spq_pkg.sv]
// Shared types and constants of the sorted priority queue.
package spq_pkg;

  localparam int unsigned SYMBOL_W = 8;
  localparam int unsigned KEY_W    = 31;
  localparam int unsigned COUNT_W  = 9;

  // Request kind carried on the mode field
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2,
    STATUS_ZERO  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PLACE,
    ST_REM,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [SYMBOL_W-1:0] symbol;
  } entry_t;

endpackage

[rtl/spq_if.sv]
// Request and response channel interfaces of the sorted priority queue.
interface spq_req_if;
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic [spq_pkg::SYMBOL_W-1:0] symbol;
  logic [spq_pkg::KEY_W-1:0]    freq_key;

  modport source (output valid, output mode, output symbol, output freq_key, input ready);
  modport sink   (input valid, input mode, input symbol, input freq_key, output ready);
endinterface

interface spq_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [spq_pkg::SYMBOL_W-1:0] out_symbol;
  logic [1:0]                   status;
  logic [spq_pkg::COUNT_W-1:0]  entry_count;

  modport source (output valid, output out_symbol, output status, output entry_count,
                  input ready);
  modport sink   (input valid, input out_symbol, input status, input entry_count,
                  output ready);
endinterface

[rtl/sorted_priority_queue_unit.sv]
// Sorted priority queue: circular entry memory kept in ascending key order.
//
// Usage: requests arrive on req (valid/ready); mode 0 inserts symbol with
// freq_key, mode 1 removes the lowest entry. Every request gives exactly one
// response on rsp carrying the removed symbol, a status and the entry count.
// Entries live in one memory used as a ring: head marks the lowest entry, so
// a remove reads the head entry and advances the pointer.
// An insert walks down from the tail through the memory read port, moving one
// entry up a slot per cycle until it meets a smaller key. An insert into an
// empty queue, and requests flagged as zero key, full or empty, finish in
// the cycle in which they are accepted. req.ready is high whenever no request
// is in progress; a finished response waits in the output register, and a
// request may be accepted while it does. If the receiver still stalls when
// the next response is finished, that response is held and no further request
// is accepted until it moves.
// Reset empties the queue at once (count and head cleared); the memory needs
// no clearing since only stored positions are ever read.
module sorted_priority_queue_unit #(
  parameter int unsigned QUEUE_DEPTH = 256
) (
  input  logic      clk,
  input  logic      rst,
  spq_req_if.sink   req,
  spq_rsp_if.source rsp
);

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  // Ring index helpers
  function automatic logic [AW-1:0] idx_next(input logic [AW-1:0] i);
    return (i == AW'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [AW-1:0] idx_prev(input logic [AW-1:0] i);
    return (i == '0) ? AW'(QUEUE_DEPTH - 1) : i - 1'b1;
  endfunction

  spq_pkg::state_t state, state_next;

  logic [AW-1:0]                head;
  logic [CW-1:0]                count;
  logic [AW-1:0]                pos;
  logic [CW-1:0]                rem;
  logic [spq_pkg::SYMBOL_W-1:0] req_symbol;
  logic [spq_pkg::KEY_W-1:0]    req_key;

  logic                         out_valid;
  logic [spq_pkg::SYMBOL_W-1:0] out_symbol;
  spq_pkg::status_t             out_status;
  logic [CW-1:0]                out_count;
  logic [spq_pkg::SYMBOL_W-1:0] held_symbol;
  spq_pkg::status_t             held_status;
  logic [CW-1:0]                held_count;

  logic                         accept;
  logic                         out_free;
  logic                         done;
  logic [spq_pkg::SYMBOL_W-1:0] res_symbol;
  spq_pkg::status_t             res_status;
  logic [CW-1:0]                res_count;
  logic                         shift;

  logic                         we;
  logic [AW-1:0]                waddr;
  spq_pkg::entry_t              wdata;
  logic [AW-1:0]                raddr;
  spq_pkg::entry_t              rdata;

  logic [AW:0]                  tail_sum;
  logic [AW-1:0]                tail;
  logic                         is_full;
  logic                         is_empty;

  assign req.ready = (state == spq_pkg::ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign out_free  = !out_valid || rsp.ready;

  // Slot just past the highest entry
  assign tail_sum = (AW + 1)'(head) + (AW + 1)'(count);
  assign tail     = (tail_sum >= (AW + 1)'(QUEUE_DEPTH)) ?
                    AW'(tail_sum - (AW + 1)'(QUEUE_DEPTH)) : AW'(tail_sum);
  assign is_full  = (count == CW'(QUEUE_DEPTH));
  assign is_empty = (count == '0);

  // Stored entry still belongs above the new one
  assign shift = (rdata.key >= req_key);

  spq_ram #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      spq_pkg::ST_IDLE: begin
        if (accept) begin
          priority if (done) begin
            state_next = out_free ? spq_pkg::ST_IDLE : spq_pkg::ST_HOLD;
          end else if (req.mode == spq_pkg::MODE_REMOVE) begin
            state_next = spq_pkg::ST_REM;
          end else begin
            state_next = spq_pkg::ST_SCAN;
          end
        end
      end
      spq_pkg::ST_SCAN: begin
        priority if (!shift) begin
          state_next = out_free ? spq_pkg::ST_IDLE : spq_pkg::ST_HOLD;
        end else if (rem == CW'(1)) begin
          state_next = spq_pkg::ST_PLACE;
        end else begin
          state_next = spq_pkg::ST_SCAN;
        end
      end
      spq_pkg::ST_PLACE, spq_pkg::ST_REM: begin
        state_next = out_free ? spq_pkg::ST_IDLE : spq_pkg::ST_HOLD;
      end
      spq_pkg::ST_HOLD: begin
        state_next = out_free ? spq_pkg::ST_IDLE : spq_pkg::ST_HOLD;
      end
      default: state_next = spq_pkg::ST_IDLE;
    endcase
  end

  // Memory controls and result of the request in progress
  always_comb begin
    done       = 1'b0;
    res_symbol = '0;
    res_status = spq_pkg::STATUS_OK;
    res_count  = count;
    we         = 1'b0;
    waddr      = pos;
    wdata      = '{key: req_key, symbol: req_symbol};
    raddr      = head;
    unique case (state)
      spq_pkg::ST_IDLE: begin
        if (accept) begin
          if (req.mode == spq_pkg::MODE_INSERT) begin
            priority if (req.freq_key == '0) begin
              done       = 1'b1;
              res_status = spq_pkg::STATUS_ZERO;
            end else if (is_full) begin
              done       = 1'b1;
              res_status = spq_pkg::STATUS_FULL;
            end else if (is_empty) begin
              done      = 1'b1;
              we        = 1'b1;
              waddr     = tail;
              wdata     = '{key: req.freq_key, symbol: req.symbol};
              res_count = count + 1'b1;
            end else begin
              raddr = idx_prev(tail);
            end
          end else begin
            if (is_empty) begin
              done       = 1'b1;
              res_status = spq_pkg::STATUS_EMPTY;
            end
          end
        end
      end
      spq_pkg::ST_SCAN: begin
        we = 1'b1;
        if (shift) begin
          // Move the entry up one slot and fetch the one below it
          wdata = rdata;
          raddr = idx_prev(idx_prev(pos));
        end else begin
          done      = 1'b1;
          res_count = count + 1'b1;
        end
      end
      spq_pkg::ST_PLACE: begin
        we        = 1'b1;
        done      = 1'b1;
        res_count = count + 1'b1;
      end
      spq_pkg::ST_REM: begin
        done       = 1'b1;
        res_symbol = rdata.symbol;
        res_count  = count - 1'b1;
      end
      spq_pkg::ST_HOLD: begin
        done = 1'b0;
      end
      default: done = 1'b0;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spq_pkg::ST_IDLE;
      head  <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      if (done) begin
        count <= res_count;
        if (state == spq_pkg::ST_REM) begin
          head <= idx_next(head);
        end
      end
    end
  end

  // Latch the request and walk the scan pointer
  always_ff @(posedge clk) begin
    if (accept) begin
      req_symbol <= req.symbol;
      req_key    <= req.freq_key;
      pos        <= tail;
      rem        <= count;
    end else if (state == spq_pkg::ST_SCAN && shift) begin
      pos <= idx_prev(pos);
      rem <= rem - 1'b1;
    end
  end

  // Hold a finished response while the output register is busy
  always_ff @(posedge clk) begin
    if (done && !out_free) begin
      held_symbol <= res_symbol;
      held_status <= res_status;
      held_count  <= res_count;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((done || state == spq_pkg::ST_HOLD) && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done && out_free) begin
      out_symbol <= res_symbol;
      out_status <= res_status;
      out_count  <= res_count;
    end else if (state == spq_pkg::ST_HOLD && out_free) begin
      out_symbol <= held_symbol;
      out_status <= held_status;
      out_count  <= held_count;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.out_symbol  = out_symbol;
  assign rsp.status      = out_status;
  assign rsp.entry_count = spq_pkg::COUNT_W'(out_count);

endmodule

[rtl/spq_ram.sv]
// Entry memory: one write port, one read port, registered read data.
module spq_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  spq_pkg::entry_t     wdata,
  input  logic [AW-1:0]       raddr,
  output spq_pkg::entry_t     rdata
);

  spq_pkg::entry_t mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[rtl/spq_checker.sv]
// Port-level checks of the sorted priority queue, bound to the top level.
module spq_checker #(
  parameter int unsigned QUEUE_DEPTH = 256
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic [spq_pkg::SYMBOL_W-1:0] out_symbol,
  input logic [1:0]                   status,
  input logic [spq_pkg::COUNT_W-1:0]  entry_count
);

  // No response straight after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  // A stalled response holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_symbol) && $stable(status)
                                && $stable(entry_count))
    else $error("stalled response changed");

  // Only a successful remove returns a symbol
  a_symbol_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != spq_pkg::STATUS_OK |-> out_symbol == '0)
    else $error("symbol returned on a flagged request");

  // Empty and full flags agree with the reported count
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == spq_pkg::STATUS_EMPTY |-> entry_count == '0)
    else $error("empty flag with entries stored");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == spq_pkg::STATUS_FULL |->
      entry_count == spq_pkg::COUNT_W'(QUEUE_DEPTH))
    else $error("full flag with free slots");

endmodule

bind sorted_priority_queue_unit spq_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_spq_checker (
  .clk         (clk),
  .rst         (rst),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .out_symbol  (rsp.out_symbol),
  .status      (rsp.status),
  .entry_count (rsp.entry_count)
);

[bench/testbench.sv]
// Self-checking bench for the sorted priority queue: directed and random requests.
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned QUEUE_DEPTH = 256;
  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned LONG_HOLD   = 500;
  localparam int unsigned TAIL_CYCLES = 50;

  typedef struct {
    logic [spq_pkg::SYMBOL_W-1:0] out_symbol;
    spq_pkg::status_t             status;
    logic [spq_pkg::COUNT_W-1:0]  entry_count;
  } queue_result_t;

  // Ordered copy of the queue contents and the responses it implies
  class sorted_queue_tracker;
    spq_pkg::entry_t ordered_entries[];
    int unsigned     depth;
    int unsigned     stored;
    queue_result_t   pending_results[$];
    int unsigned     mismatch_count;

    function new(int unsigned queue_depth);
      depth           = queue_depth;
      ordered_entries = new[queue_depth];
      stored          = 0;
      mismatch_count  = 0;
    endfunction

    function int unsigned outstanding();
      return pending_results.size();
    endfunction

    function int unsigned entries_held();
      return stored;
    endfunction

    // Apply one accepted request and queue the response it must produce
    function void note_request(logic mode, logic [spq_pkg::SYMBOL_W-1:0] sym,
                               logic [spq_pkg::KEY_W-1:0] key);
      queue_result_t res;
      int unsigned   pos;
      int unsigned   idx;
      res.out_symbol = '0;
      res.status     = spq_pkg::STATUS_OK;
      if (mode == spq_pkg::MODE_INSERT) begin
        if (key == '0) begin
          res.status = spq_pkg::STATUS_ZERO;
        end else if (stored >= depth) begin
          res.status = spq_pkg::STATUS_FULL;
        end else begin
          // place ahead of the first entry with an equal or larger key
          pos = 0;
          while (pos < stored && key > ordered_entries[pos].key) pos++;
          for (idx = stored; idx > pos; idx--) ordered_entries[idx] = ordered_entries[idx-1];
          ordered_entries[pos].key    = key;
          ordered_entries[pos].symbol = sym;
          stored++;
        end
      end else begin
        if (stored == 0) begin
          res.status = spq_pkg::STATUS_EMPTY;
        end else begin
          // take the lowest entry and close the gap
          res.out_symbol = ordered_entries[0].symbol;
          for (idx = 1; idx < stored; idx++) ordered_entries[idx-1] = ordered_entries[idx];
          stored--;
        end
      end
      res.entry_count = spq_pkg::COUNT_W'(stored);
      pending_results.push_back(res);
    endfunction

    task report_mismatch(string what, int unsigned got, int unsigned want);
      mismatch_count++;
      $display("mismatch at %0t: %s, got %0d, want %0d", $realtime, what, got, want);
    endtask

    // Compare one accepted response with the oldest expectation
    task check_response(logic [spq_pkg::SYMBOL_W-1:0] sym, logic [1:0] status,
                        logic [spq_pkg::COUNT_W-1:0] count);
      queue_result_t res;
      if (pending_results.size() == 0) begin
        report_mismatch("response with nothing outstanding, entry_count", count, 0);
      end else begin
        res = pending_results.pop_front();
        if (sym !== res.out_symbol)
          report_mismatch("out_symbol", sym, res.out_symbol);
        if (status !== res.status)
          report_mismatch("status", status, res.status);
        if (count !== res.entry_count)
          report_mismatch("entry_count", count, res.entry_count);
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;

  spq_req_if req_ch ();
  spq_rsp_if rsp_ch ();

  sorted_priority_queue_unit #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  sorted_queue_tracker board;
  int unsigned         send_idle_pct;
  int unsigned         recv_idle_pct;
  bit                  long_hold_req;
  int unsigned         cycle_count = 0;

  always #5 clk = ~clk;

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Collect responses and drive ready, with random stalls and one long hold-off
  initial begin : response_side
    int unsigned hold_left;
    hold_left = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready)
        board.check_response(rsp_ch.out_symbol, rsp_ch.status, rsp_ch.entry_count);
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = LONG_HOLD;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offer one request, idling first at random, and hold it until accepted
  task automatic send_request(input logic mode, input logic [spq_pkg::SYMBOL_W-1:0] sym,
                              input logic [spq_pkg::KEY_W-1:0] key);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.mode     <= mode;
    req_ch.symbol   <= sym;
    req_ch.freq_key <= key;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    board.note_request(mode, sym, key);
  endtask

  // Stop offering until every expected response has arrived
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (board.outstanding() > 0) @(posedge clk);
  endtask

  // Mix of tied small keys, keys near the top, full-range keys and the odd zero
  function automatic logic [spq_pkg::KEY_W-1:0] pick_key(input bit allow_zero);
    int unsigned               kind;
    logic [spq_pkg::KEY_W-1:0] key;
    kind = $urandom_range(99);
    if (kind < 3 && allow_zero)
      key = '0;
    else if (kind < 40)
      key = spq_pkg::KEY_W'($urandom_range(8, 1));
    else if (kind < 50)
      key = {spq_pkg::KEY_W{1'b1}} - spq_pkg::KEY_W'($urandom_range(3));
    else
      key = spq_pkg::KEY_W'($urandom);
    if (key == '0 && !allow_zero)
      key = spq_pkg::KEY_W'(1);
    return key;
  endfunction

  // Random inserts and removes; ignored zero-key inserts are not counted
  task automatic run_mix(input int unsigned count, input int unsigned insert_pct);
    int unsigned               done;
    logic                      mode;
    logic [spq_pkg::KEY_W-1:0] key;
    done = 0;
    while (done < count) begin
      mode = ($urandom_range(99) < insert_pct) ? spq_pkg::MODE_INSERT : spq_pkg::MODE_REMOVE;
      key  = pick_key(1'b1);
      send_request(mode, spq_pkg::SYMBOL_W'($urandom), key);
      if (mode == spq_pkg::MODE_REMOVE || key != '0) done++;
    end
  endtask

  // Insert until the queue is full, then keep pushing into the full queue
  task automatic fill_past_full();
    int unsigned extra;
    while (board.entries_held() < QUEUE_DEPTH)
      send_request(spq_pkg::MODE_INSERT, spq_pkg::SYMBOL_W'($urandom), pick_key(1'b0));
    for (extra = 0; extra < 12; extra++)
      send_request(spq_pkg::MODE_INSERT, spq_pkg::SYMBOL_W'($urandom),
                   (extra == 5) ? '0 : pick_key(1'b0));
  endtask

  initial begin
    board = new(QUEUE_DEPTH);
    send_idle_pct = 10;
    recv_idle_pct = 75;
    long_hold_req = 1'b0;
    rst             <= 1'b1;
    req_ch.valid    <= 1'b0;
    req_ch.mode     <= spq_pkg::MODE_INSERT;
    req_ch.symbol   <= '0;
    req_ch.freq_key <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty remove, zero key, key extremes, ties, removal order
    send_request(spq_pkg::MODE_REMOVE, 8'h00, '0);
    send_request(spq_pkg::MODE_INSERT, 8'hFF, '0);
    send_request(spq_pkg::MODE_INSERT, 8'h00, {spq_pkg::KEY_W{1'b1}});
    send_request(spq_pkg::MODE_INSERT, 8'h01, spq_pkg::KEY_W'(1));
    send_request(spq_pkg::MODE_INSERT, 8'hA5, spq_pkg::KEY_W'(1));
    send_request(spq_pkg::MODE_INSERT, 8'h5A, {spq_pkg::KEY_W{1'b1}});
    send_request(spq_pkg::MODE_INSERT, 8'h3C, spq_pkg::KEY_W'(32'h4000_0000));
    send_request(spq_pkg::MODE_INSERT, 8'h00, '0);
    repeat (5) send_request(spq_pkg::MODE_REMOVE, 8'hFF, {spq_pkg::KEY_W{1'b1}});
    send_request(spq_pkg::MODE_REMOVE, 8'h00, '0);
    send_request(spq_pkg::MODE_INSERT, 8'h80, spq_pkg::KEY_W'(2));
    send_request(spq_pkg::MODE_REMOVE, 8'h00, '0);

    // Sender mostly busy, receiver mostly stalled
    run_mix(200, 70);
    run_mix(150, 20);
    wait_drained();

    // Sender mostly idle, receiver mostly ready: fill to full, then drain past empty
    send_idle_pct = 75;
    recv_idle_pct = 10;
    fill_past_full();
    run_mix(320, 5);
    wait_drained();

    // No idling; hold the receiver off so the queue backs up against the sender
    send_idle_pct = 0;
    recv_idle_pct = 0;
    long_hold_req = 1'b1;
    run_mix(300, 55);
    run_mix(150, 40);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.mismatch_count == 0 && board.outstanding() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
